// ===== src/dht_pkg.sv =====
// shared types and constants for the double hash table engine
package dht_pkg;

   localparam logic [1:0] CMD_GET    = 2'd0;
   localparam logic [1:0] CMD_SET    = 2'd1;
   localparam logic [1:0] CMD_TEST   = 2'd2;
   localparam logic [1:0] CMD_DELETE = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_UNINIT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   localparam logic [1:0] MARK_EMPTY   = 2'd0;
   localparam logic [1:0] MARK_USED    = 2'd1;
   localparam logic [1:0] MARK_DELETED = 2'd2;

   localparam logic [2:0] REG_TABLE_SIZE      = 3'd0;
   localparam logic [2:0] REG_REHASH_MODULUS  = 3'd1;
   localparam logic [2:0] REG_MAX_ENTRIES     = 3'd2;
   localparam logic [2:0] REG_DEFAULT_PRESENT = 3'd3;
   localparam logic [2:0] REG_DEFAULT_VALUE   = 3'd4;

   localparam logic [11:0] RESET_TABLE_SIZE     = 12'd1153;
   localparam logic [11:0] RESET_REHASH_MODULUS = 12'd1151;
   localparam logic [11:0] RESET_MAX_ENTRIES    = 12'd1024;

   localparam int CFG_BITS = 32;
   localparam int MOD_BITS = 12;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_MOD,
      ST_STEP,
      ST_READ,
      ST_CHECK,
      ST_DECIDE,
      ST_WRITE,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_req;
      logic mod_start;
      logic calc_step;
      logic mem_read;
      logic check;
      logic decide;
      logic write;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic mod_done;
      logic probe_done;
   } sts_type;

endpackage

// ===== src/dht_if.sv =====
// valid/ready channel interface
interface dht_if #(parameter int PAYLOAD_BITS = 8);
   logic                    valid;
   logic                    ready;
   logic [PAYLOAD_BITS-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/double_hash_table_engine_core.sv =====
// Double hash table engine: top level with config registers and channels.
// Sequence from accept to result valid: modulo and step reduction, a handoff, step setup,
// a read and a check per probed slot, then decide, write and output.
// Throughput: one request at a time; the bit-serial modulo unit and the single
// slot memory port set this.
// After reset a clearing pass empties the slots; no request is taken during it.
// Registers return to their reset values.
module double_hash_table_engine_core #(
   parameter int SLOT_CAPACITY = 2048,
   parameter int KEY_BITS = 32,
   parameter int DATA_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   dht_if.sink   req,
   dht_if.source rsp,
   input  logic                            csr_write_enable,
   input  logic [2:0]                      csr_index,
   input  logic [dht_pkg::CFG_BITS-1:0]    csr_write_data
);
   import dht_pkg::*;

   logic [11:0] table_size_ff, rehash_modulus_ff, max_entries_ff;
   logic        default_present_ff;
   logic [DATA_BITS-1:0] default_value_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= RESET_TABLE_SIZE;
         rehash_modulus_ff <= RESET_REHASH_MODULUS;
         max_entries_ff <= RESET_MAX_ENTRIES;
         default_present_ff <= 1'b0;
         default_value_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TABLE_SIZE:      table_size_ff <= csr_write_data[11:0];
            REG_REHASH_MODULUS:  rehash_modulus_ff <= csr_write_data[11:0];
            REG_MAX_ENTRIES:     max_entries_ff <= csr_write_data[11:0];
            REG_DEFAULT_PRESENT: default_present_ff <= csr_write_data[0];
            REG_DEFAULT_VALUE:   default_value_ff <= DATA_BITS'(csr_write_data);
            default: ;
         endcase
      end
   end

   cmd_type cmd;
   sts_type sts;
   logic rsp_valid_ff;

   dht_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_busy(rsp_valid_ff && !rsp.ready),
      .sts(sts), .cmd(cmd)
   );

   logic [31:0] rv;
   logic        fnd;
   logic [1:0]  stat;

   dht_datapath #(
      .SLOT_CAPACITY(SLOT_CAPACITY), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_cmd(req.payload[97:96]),
      .req_key(KEY_BITS'(req.payload[95:64])),
      .req_key_hash(req.payload[63:32]),
      .req_new_value(DATA_BITS'(req.payload[31:0])),
      .table_size(table_size_ff), .rehash_modulus(rehash_modulus_ff),
      .max_entries(max_entries_ff), .default_present(default_present_ff),
      .default_value(default_value_ff),
      .rsp_read_value(rv), .rsp_found(fnd), .rsp_status(stat)
   );

   // result valid
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
   end
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = {rv, fnd, stat};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !rsp_valid_ff || rsp.ready) else $error("result overwritten");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid) else $error("result dropped");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload[1:0] != 2'd3) else $error("bad status");
endmodule

// ===== src/dht_ctrl.sv =====
// control state machine of the hash table engine
module dht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             rsp_busy,
   input  dht_pkg::sts_type sts,
   output dht_pkg::cmd_type cmd
);
   import dht_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:  if (sts.clear_done) state_in = ST_IDLE;
         ST_IDLE:   if (req_valid) state_in = ST_MOD;
         ST_MOD:    if (sts.mod_done) state_in = ST_STEP;
         ST_STEP:   state_in = ST_READ;
         ST_READ:   state_in = ST_CHECK;
         ST_CHECK:  state_in = sts.probe_done ? ST_DECIDE : ST_READ;
         ST_DECIDE: state_in = ST_WRITE;
         ST_WRITE:  state_in = ST_OUT;
         ST_OUT:    if (!rsp_busy) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_req = req_valid;
            cmd.mod_start = req_valid;
         end
         ST_STEP:   cmd.calc_step = 1'b1;
         ST_READ:   cmd.mem_read = 1'b1;
         ST_CHECK:  cmd.check = 1'b1;
         ST_DECIDE: cmd.decide = 1'b1;
         ST_WRITE:  cmd.write = 1'b1;
         ST_OUT:    cmd.out_load = !rsp_busy;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   // requests only taken when idle
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE) else $error("ready outside idle");
   a_clear_first: assert property (@(posedge clock)
      $past(reset) && !reset |-> state_ff == ST_CLEAR) else $error("no clear after reset");
   a_out_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == ST_IDLE) else $error("output not followed by idle");
endmodule

// ===== src/dht_datapath.sv =====
// slot memories, modulo unit, probe walk and result register
module dht_datapath #(
   parameter int SLOT_CAPACITY = 2048,
   parameter int KEY_BITS = 32,
   parameter int DATA_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dht_pkg::cmd_type      cmd,
   output dht_pkg::sts_type      sts,
   input  logic [1:0]            req_cmd,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [31:0]           req_key_hash,
   input  logic [DATA_BITS-1:0]  req_new_value,
   input  logic [11:0]           table_size,
   input  logic [11:0]           rehash_modulus,
   input  logic [11:0]           max_entries,
   input  logic                  default_present,
   input  logic [DATA_BITS-1:0]  default_value,
   output logic [31:0]           rsp_read_value,
   output logic                  rsp_found,
   output logic [1:0]            rsp_status
);
   import dht_pkg::*;

   localparam int AW = $clog2(SLOT_CAPACITY);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] CAP = CW'(SLOT_CAPACITY);

   logic [1:0]           mark_mem [SLOT_CAPACITY];
   logic [31:0]          hash_mem [SLOT_CAPACITY];
   logic [KEY_BITS-1:0]  key_mem  [SLOT_CAPACITY];
   logic [DATA_BITS-1:0] data_mem [SLOT_CAPACITY];

   logic [1:0]           cmd_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic [31:0]          hash_ff;
   logic [DATA_BITS-1:0] nval_ff;
   logic [AW-1:0]        clr_ff;
   logic                 clr_done_ff;

   // effective table size
   logic [CW-1:0] size_eff;
   always_comb begin
      if (table_size == '0) size_eff = CW'(1);
      else if (32'(table_size) > 32'(SLOT_CAPACITY)) size_eff = CAP;
      else size_eff = CW'(table_size);
   end

   // two restoring dividers run together, one quotient bit per cycle,
   // then the 12-bit step is reduced modulo the table size bit by bit
   logic [31:0]   rem_a_ff, rem_b_ff;
   logic [31:0]   quo_a_ff, quo_b_ff;
   logic [CW-1:0] srem_ff;
   logic [11:0]   squo_ff;
   logic [5:0]    mbit_ff;
   logic          mbusy_ff, mdone_ff;
   logic [32:0]   ta, tb;
   logic [31:0]   rem_b_nxt;
   logic [CW:0]   ts;
   assign ta = {rem_a_ff, quo_a_ff[31]};
   assign tb = {rem_b_ff, quo_b_ff[31]};
   assign rem_b_nxt = (tb >= 33'(rehash_modulus)) ? 32'(tb - 33'(rehash_modulus)) : tb[31:0];
   assign ts = {srem_ff, squo_ff[11]};

   always_ff @(posedge clock) begin
      if (reset) mbusy_ff <= 1'b0;
      else if (cmd.mod_start) mbusy_ff <= 1'b1;
      else if (mbusy_ff && mbit_ff == 6'd43) mbusy_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) mdone_ff <= 1'b0;
      else mdone_ff <= mbusy_ff && !cmd.mod_start && mbit_ff == 6'd43;
   end

   always_ff @(posedge clock) begin
      if (cmd.mod_start) begin
         mbit_ff <= 6'd0;
         rem_a_ff <= '0;
         rem_b_ff <= '0;
         quo_a_ff <= req_key_hash;
         quo_b_ff <= req_key_hash;
      end else if (mbusy_ff) begin
         mbit_ff <= mbit_ff + 6'd1;
         if (mbit_ff < 6'd32) begin
            rem_a_ff <= (ta >= 33'(size_eff)) ? 32'(ta - 33'(size_eff)) : ta[31:0];
            rem_b_ff <= rem_b_nxt;
            quo_a_ff <= quo_a_ff << 1;
            quo_b_ff <= quo_b_ff << 1;
            // hand the raw step to the reduction stage
            if (mbit_ff == 6'd31) begin
               srem_ff <= '0;
               squo_ff <= (rehash_modulus == '0) ? 12'd1 : rem_b_nxt[11:0];
            end
         end else begin
            srem_ff <= (ts >= (CW+1)'(size_eff)) ? CW'(ts - (CW+1)'(size_eff)) : CW'(ts);
            squo_ff <= squo_ff << 1;
         end
      end
   end

   // probe state
   logic [AW-1:0] elt_ff, step_ff, tomb_ff, pos_ff;
   logic [CW-1:0] cnt_ff;
   logic          tomb_seen_ff, hit_ff, have_ff, done_ff;
   logic [1:0]    m_rd_ff;
   logic [31:0]   h_rd_ff;
   logic [KEY_BITS-1:0]  k_rd_ff;
   logic [DATA_BITS-1:0] d_rd_ff;
   logic [11:0]   live_ff;

   logic [CW-1:0] nxt;
   assign nxt = CW'(elt_ff) + CW'(step_ff);

   // decision
   logic do_ins, do_upd, do_del, ins_ok;
   logic [DATA_BITS-1:0] wdata;
   logic [1:0] status_in;
   logic [31:0] rv_in;
   always_comb begin
      ins_ok = have_ff && (live_ff < max_entries);
      do_ins = 1'b0;
      do_upd = 1'b0;
      do_del = 1'b0;
      wdata = nval_ff;
      status_in = STATUS_OK;
      rv_in = '0;
      case (cmd_ff)
         CMD_GET: begin
            wdata = default_value;
            if (hit_ff) rv_in = 32'(d_rd_ff);
            else if (!default_present) status_in = STATUS_UNINIT;
            else if (ins_ok) begin
               do_ins = 1'b1;
               rv_in = 32'(default_value);
            end else status_in = STATUS_FULL;
         end
         CMD_SET: begin
            if (hit_ff) do_upd = 1'b1;
            else if (ins_ok) do_ins = 1'b1;
            else status_in = STATUS_FULL;
         end
         CMD_DELETE: do_del = hit_ff;
         default: status_in = STATUS_OK;
      endcase
   end

   logic act_ins_ff, act_upd_ff, act_del_ff;
   logic [DATA_BITS-1:0] wdata_ff;
   logic [1:0]  st_ff;
   logic [31:0] rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
         live_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         // clearing pass over slot marks
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + AW'(1);
            if (clr_ff == AW'(SLOT_CAPACITY - 1)) clr_done_ff <= 1'b1;
         end
         if (cmd.calc_step) begin
            elt_ff <= AW'(rem_a_ff);
            step_ff <= (srem_ff == '0) ? AW'(1) : AW'(srem_ff);
            cnt_ff <= '0;
            tomb_seen_ff <= 1'b0;
            tomb_ff <= '0;
            hit_ff <= 1'b0;
            have_ff <= 1'b0;
            done_ff <= 1'b0;
         end
         if (cmd.check) begin
            if (m_rd_ff == MARK_USED && h_rd_ff == hash_ff && k_rd_ff == key_ff) begin
               hit_ff <= 1'b1;
               have_ff <= 1'b1;
               pos_ff <= elt_ff;
               done_ff <= 1'b1;
            end else if (m_rd_ff == MARK_EMPTY) begin
               have_ff <= 1'b1;
               pos_ff <= tomb_seen_ff ? tomb_ff : elt_ff;
               done_ff <= 1'b1;
            end else begin
               if (m_rd_ff == MARK_DELETED && !tomb_seen_ff) begin
                  tomb_seen_ff <= 1'b1;
                  tomb_ff <= elt_ff;
               end
               elt_ff <= AW'((nxt >= size_eff) ? nxt - size_eff : nxt);
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff + CW'(1) >= size_eff) begin
                  done_ff <= 1'b1;
                  have_ff <= tomb_seen_ff || m_rd_ff == MARK_DELETED;
                  pos_ff <= tomb_seen_ff ? tomb_ff : elt_ff;
               end
            end
         end
         if (cmd.decide) begin
            act_ins_ff <= do_ins;
            act_upd_ff <= do_upd;
            act_del_ff <= do_del;
            wdata_ff <= wdata;
            st_ff <= status_in;
            rv_ff <= rv_in;
         end
         if (cmd.write) begin
            if (act_ins_ff) live_ff <= live_ff + 12'd1;
            else if (act_del_ff && live_ff != '0) live_ff <= live_ff - 12'd1;
         end
      end
   end

   // request capture, result register
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key;
         hash_ff <= req_key_hash;
         nval_ff <= req_new_value;
      end
      if (cmd.out_load) begin
         rsp_read_value <= rv_ff;
         rsp_found <= hit_ff;
         rsp_status <= st_ff;
      end
   end

   // slot memories
   always_ff @(posedge clock) begin
      if (cmd.clear_step) mark_mem[clr_ff] <= MARK_EMPTY;
      else if (cmd.write && (act_ins_ff || act_del_ff))
         mark_mem[pos_ff] <= act_ins_ff ? MARK_USED : MARK_DELETED;
      if (cmd.mem_read) m_rd_ff <= mark_mem[elt_ff];
   end
   always_ff @(posedge clock) begin
      if (cmd.write && act_ins_ff) begin
         hash_mem[pos_ff] <= hash_ff;
         key_mem[pos_ff] <= key_ff;
      end
      if (cmd.mem_read) begin
         h_rd_ff <= hash_mem[elt_ff];
         k_rd_ff <= key_mem[elt_ff];
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.write && (act_ins_ff || act_upd_ff)) data_mem[pos_ff] <= wdata_ff;
      if (cmd.mem_read) d_rd_ff <= data_mem[elt_ff];
   end

   assign sts.clear_done = clr_done_ff;
   assign sts.mod_done = mdone_ff;
   assign sts.probe_done = done_ff || (cmd.check && (m_rd_ff != MARK_DELETED &&
      (m_rd_ff != MARK_USED || (h_rd_ff == hash_ff && k_rd_ff == key_ff)) ||
      cnt_ff + CW'(1) >= size_eff));

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.write && act_ins_ff |-> live_ff < max_entries) else $error("insert past limit");
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> $onehot0({act_ins_ff, act_upd_ff, act_del_ff}))
      else $error("conflicting slot actions");
   a_hit_have: assert property (@(posedge clock) disable iff (reset)
      cmd.decide && hit_ff |-> have_ff) else $error("hit without slot");
endmodule

// ===== test/double_hash_table_engine_core_test.sv =====
// self-checking testbench for the double hash table engine core
module double_hash_table_engine_core_test;
   import dht_pkg::*;

   localparam int CAPACITY = 2048;
   localparam int REQ_BITS = 2 + 32 + 32 + 32;
   localparam int RSP_BITS = 32 + 1 + 2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [31:0] key_hash;
      logic [31:0] new_value;
   } request_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        found;
      logic [1:0]  status;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = REG_TABLE_SIZE;
   logic [31:0] csr_write_data = '0;

   dht_if #(.PAYLOAD_BITS(REQ_BITS)) req_ch ();
   dht_if #(.PAYLOAD_BITS(RSP_BITS)) rsp_ch ();

   double_hash_table_engine_core dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // shadow copy of the table and its registers
   logic [11:0] size_reg, rehash_reg, max_entries_reg;
   logic        default_present_reg;
   logic [31:0] default_value_reg;
   logic [1:0]  mark_mem [CAPACITY];
   logic [31:0] hash_mem [CAPACITY];
   logic [31:0] key_mem [CAPACITY];
   logic [31:0] data_mem [CAPACITY];
   int unsigned live_entries;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   int  fail_count = 0;
   bit  no_idle = 1'b0;
   bit  hold_armed = 1'b0;
   bit  hold_done = 1'b0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %h expected %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   // probe walk and command effect for one accepted request
   task automatic compute_response(input request_type r, output response_type o);
      int unsigned sz, elt, stride, tomb, i;
      bit tomb_seen, hit, have, done;
      int unsigned pos;
      tomb = 0; tomb_seen = 0; hit = 0; have = 0; done = 0; pos = 0;
      sz = size_reg;
      if (sz == 0) sz = 1;
      if (sz > CAPACITY) sz = CAPACITY;
      elt = r.key_hash % sz;
      stride = (rehash_reg != 0) ? (r.key_hash % rehash_reg) : 1;
      stride = stride % sz;
      if (stride == 0) stride = 1;
      for (i = 0; i < sz && !done; i++) begin
         if (mark_mem[elt] == MARK_USED) begin
            if (hash_mem[elt] == r.key_hash && key_mem[elt] == r.key) begin
               pos = elt; have = 1; hit = 1; done = 1;
            end
         end else if (mark_mem[elt] == MARK_DELETED) begin
            if (!tomb_seen) begin
               tomb_seen = 1; tomb = elt;
            end
         end else begin
            pos = tomb_seen ? tomb : elt; have = 1; done = 1;
         end
         if (!done) begin
            elt += stride;
            if (elt >= sz) elt -= sz;
         end
      end
      if (!done) begin
         pos = tomb; have = tomb_seen;
      end
      o = '0;
      o.found = hit;
      case (r.cmd)
         CMD_GET: begin
            if (hit) o.read_value = data_mem[pos];
            else if (!default_present_reg) o.status = STATUS_UNINIT;
            else if (have && live_entries < max_entries_reg) begin
               mark_mem[pos] = MARK_USED; hash_mem[pos] = r.key_hash;
               key_mem[pos] = r.key; data_mem[pos] = default_value_reg;
               live_entries++;
               o.read_value = default_value_reg;
            end else o.status = STATUS_FULL;
         end
         CMD_SET: begin
            if (hit) data_mem[pos] = r.new_value;
            else if (have && live_entries < max_entries_reg) begin
               mark_mem[pos] = MARK_USED; hash_mem[pos] = r.key_hash;
               key_mem[pos] = r.key; data_mem[pos] = r.new_value;
               live_entries++;
            end else o.status = STATUS_FULL;
         end
         CMD_DELETE: begin
            if (hit) begin
               mark_mem[pos] = MARK_DELETED;
               if (live_entries > 0) live_entries--;
            end
         end
         default: ;
      endcase
   endtask

   // request driver
   int send_gap = 0;
   always @(posedge clock) begin
      request_type  r;
      response_type o;
      bit busy;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.payload <= '0;
      end else begin
         busy = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            r = req_ch.payload;
            compute_response(r, o);
            expected_responses.push_back(o);
            busy = 1'b0;
         end
         if (!busy) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_ch.payload <= pending_requests.pop_front();
               req_ch.valid <= 1'b1;
               send_gap <= no_idle ? 0 : $urandom_range(0, 9);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random stalls and one long hold-off
   int recv_stall = 0;
   int hold_count = 0;
   always @(posedge clock) begin
      response_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.payload;
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response", got.read_value, 32'd0);
            end else begin
               want = expected_responses.pop_front();
               if (got.read_value !== want.read_value)
                  report_mismatch("read_value", got.read_value, want.read_value);
               if (got.found !== want.found)
                  report_mismatch("found", got.found, want.found);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
            end
            recv_stall <= no_idle ? 0 : $urandom_range(0, 9);
            rsp_ch.ready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            if (hold_count < 800) begin
               hold_count <= hold_count + 1;
               rsp_ch.ready <= 1'b0;
            end else begin
               hold_done <= 1'b1;
               rsp_ch.ready <= 1'b1;
            end
         end else if (recv_stall > 0) begin
            recv_stall <= recv_stall - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() > 0 || expected_responses.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         REG_TABLE_SIZE:      size_reg = value[11:0];
         REG_REHASH_MODULUS:  rehash_reg = value[11:0];
         REG_MAX_ENTRIES:     max_entries_reg = value[11:0];
         REG_DEFAULT_PRESENT: default_present_reg = value[0];
         REG_DEFAULT_VALUE:   default_value_reg = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [11:0] sz, input logic [11:0] rh,
                            input logic [11:0] me, input logic dp, input logic [31:0] dv);
      wait_drained();
      write_register(REG_TABLE_SIZE, sz);
      write_register(REG_REHASH_MODULUS, rh);
      write_register(REG_MAX_ENTRIES, me);
      write_register(REG_DEFAULT_PRESENT, dp);
      write_register(REG_DEFAULT_VALUE, dv);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_request(input logic [1:0] c, input logic [31:0] k,
                              input logic [31:0] h, input logic [31:0] v);
      request_type r;
      r.cmd = c; r.key = k; r.key_hash = h; r.new_value = v;
      pending_requests.push_back(r);
   endtask

   // random requests over a small key pool so that hits and collisions happen
   task automatic queue_random(input int count);
      logic [31:0] pool_keys [24];
      logic [31:0] pool_hashes [24];
      int idx, pick;
      logic [1:0] c;
      for (int i = 0; i < 24; i++) begin
         pool_keys[i] = $urandom;
         pool_hashes[i] = (i % 6 == 0 && i > 0) ? pool_hashes[0] : $urandom;
      end
      for (int i = 0; i < count; i++) begin
         idx = $urandom_range(0, 23);
         pick = $urandom_range(0, 99);
         c = (pick < 30) ? CMD_GET : (pick < 65) ? CMD_SET : (pick < 80) ? CMD_TEST
             : CMD_DELETE;
         if ($urandom_range(0, 9) == 0)
            add_request(c, $urandom, $urandom, $urandom);
         else if ($urandom_range(0, 7) == 0)
            add_request(c, pool_keys[idx], pool_hashes[$urandom_range(0, 23)], $urandom);
         else
            add_request(c, pool_keys[idx], pool_hashes[idx], $urandom);
      end
   endtask

   initial begin
      size_reg = RESET_TABLE_SIZE;
      rehash_reg = RESET_REHASH_MODULUS;
      max_entries_reg = RESET_MAX_ENTRIES;
      default_present_reg = 1'b0;
      default_value_reg = '0;
      live_entries = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         mark_mem[i] = MARK_EMPTY;
         hash_mem[i] = '0; key_mem[i] = '0; data_mem[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, every command, hits, misses, tombstones
      add_request(CMD_GET, 32'h0, 32'h0, 32'h0);
      add_request(CMD_SET, 32'h0, 32'h0, 32'hffffffff);
      add_request(CMD_GET, 32'h0, 32'h0, 32'h0);
      add_request(CMD_SET, 32'h0, 32'h0, 32'h12345678);
      add_request(CMD_GET, 32'h0, 32'h0, 32'hffffffff);
      add_request(CMD_SET, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      add_request(CMD_TEST, 32'hffffffff, 32'hffffffff, 32'h0);
      add_request(CMD_SET, 32'h1, 32'h0, 32'h5a5a5a5a);
      add_request(CMD_GET, 32'h1, 32'h0, 32'h0);
      add_request(CMD_TEST, 32'h1, 32'h1, 32'h0);
      add_request(CMD_DELETE, 32'h0, 32'h0, 32'h0);
      add_request(CMD_DELETE, 32'h0, 32'h0, 32'h0);
      add_request(CMD_TEST, 32'h1, 32'h0, 32'h0);
      add_request(CMD_SET, 32'h2, 32'h0, 32'ha5a5a5a5);
      add_request(CMD_GET, 32'h2, 32'h0, 32'h0);
      add_request(CMD_DELETE, 32'h7, 32'h480, 32'h0);
      add_request(CMD_GET, 32'hffffffff, 32'hffffffff, 32'h0);
      add_request(CMD_DELETE, 32'hffffffff, 32'hffffffff, 32'h0);
      add_request(CMD_GET, 32'hffffffff, 32'hffffffff, 32'h0);
      queue_random(130);
      wait_drained();

      // tiny table with default inserts, fills up
      configure(12'd3, 12'd1, 12'd4095, 1'b1, 32'hffffffff);
      queue_random(80);
      // largest prime table; receiver holds off while the sender keeps offering requests
      configure(12'd2039, 12'd2037, 12'd2048, 1'b0, 32'h0);
      hold_armed = 1'b1;
      queue_random(120);
      configure(12'd31, 12'd29, 12'd5, 1'b1, $urandom);
      queue_random(100);
      // oversized table and modulus, no room for any entry
      configure(12'd4095, 12'd4095, 12'd0, 1'b1, 32'h0f0f0f0f);
      queue_random(40);
      // zero size and zero step
      configure(12'd0, 12'd0, 12'd1, 1'b1, 32'h80000001);
      queue_random(30);
      no_idle = 1'b1;
      configure(12'd61, 12'd59, 12'd4095, 1'b1, $urandom);
      queue_random(200);
      no_idle = 1'b0;
      configure(12'd127, 12'd0, 12'd100, 1'b0, 32'h0);
      queue_random(200);
      configure(12'd13, 12'd11, 12'd13, 1'b1, 32'h0);
      queue_random(180);

      wait_drained();
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #200000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
